// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TXTKV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TXTKV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/txtkv_pkg.sv =====
`timescale 1ns / 1ps
package txtkv_pkg;

   localparam int KEY_COUNT   = 8;
   localparam int NAME_SLOTS  = 8;
   localparam int ACTIVE_KEYS = (KEY_COUNT < NAME_SLOTS) ? KEY_COUNT : NAME_SLOTS;
   localparam int KEY_W       = 3;
   localparam int POS_W       = 4;

   localparam logic [7:0] MIN_LEN     = 8'd3;
   localparam logic [7:0] ASSIGN_CHAR = 8'h3D;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] KIND_VALUE  = 2'd0;
   localparam logic [1:0] KIND_COMMIT = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   typedef enum logic [1:0] {
      PH_LEN = 2'd0,
      PH_KEY = 2'd1,
      PH_VAL = 2'd2
   } phase_type;

   // One entry of the queue: the results that one input byte causes.
   typedef struct packed {
      logic             do_value;
      logic             do_commit;
      logic             do_end;
      logic             end_err;
      logic [KEY_W-1:0] key;
      logic [7:0]       data;
   } cmd_type;

   function automatic logic [POS_W-1:0] name_len(input logic [KEY_W-1:0] k);
      logic [POS_W-1:0] len;
      case (k)
         3'd0:    len = 4'd7;
         3'd1:    len = 4'd2;
         3'd2:    len = 4'd4;
         3'd3:    len = 4'd3;
         3'd4:    len = 4'd8;
         3'd5:    len = 4'd5;
         3'd6:    len = 4'd4;
         3'd7:    len = 4'd5;
         default: len = 4'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] name_char(input logic [KEY_W-1:0] k,
                                            input logic [2:0] pos);
      logic [63:0] text;
      case (k)
         3'd0:    text = {"txtvers", 8'h00};
         3'd1:    text = {"id", 48'h0};
         3'd2:    text = {"path", 32'h0};
         3'd3:    text = {"ski", 40'h0};
         3'd4:    text = "register";
         3'd5:    text = {"brand", 24'h0};
         3'd6:    text = {"type", 32'h0};
         3'd7:    text = {"model", 24'h0};
         default: text = 64'h0;
      endcase
      return text[63 - 8 * int'(pos) -: 8];
   endfunction

endpackage

// ===== design/txtkv_if.sv =====
`timescale 1ns / 1ps
interface txtkv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface txtkv_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [2:0] key_index;
   logic [7:0] value_byte;
   logic       parse_error;
   logic       run_last;

   modport source (output valid, output kind, output key_index, output value_byte,
                   output parse_error, output run_last, input ready);
   modport sink (input valid, input kind, input key_index, input value_byte,
                 input parse_error, input run_last, output ready);
endinterface

// ===== design/txtkv_front.sv =====
`timescale 1ns / 1ps
module txtkv_front import txtkv_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   txtkv_req_if.sink req_ch,
   input  logic    q_full,
   output logic    q_push,
   output cmd_type q_cmd
);

   phase_type              phase_ff, phase_in;
   logic [7:0]             togo_ff, togo_in;
   logic [POS_W-1:0]       keypos_ff, keypos_in;
   logic [ACTIVE_KEYS-1:0] cand_ff, cand_in;
   logic [ACTIVE_KEYS-1:0] lock_ff, lock_in;
   logic                   mvalid_ff, mvalid_in;
   logic [KEY_W-1:0]       mkey_ff, mkey_in;
   logic                   err_seen_ff, err_seen_in;

   logic [ACTIVE_KEYS-1:0] cand_nx, lock_nx;
   logic [KEY_W-1:0]       pick;
   logic [7:0]             b;
   logic                   fin;

   assign b   = req_ch.data_byte;
   assign fin = req_ch.final_byte;
   assign req_ch.ready = !q_full;

   // Parallel compare of the key byte against every name still in play.
   always_comb begin
      cand_nx = cand_ff;
      lock_nx = lock_ff;
      pick    = '0;
      for (int k = 0; k < ACTIVE_KEYS; k++) begin
         if (cand_ff[k] && !lock_ff[k]) begin
            if (keypos_ff < name_len(KEY_W'(k))) begin
               if (name_char(KEY_W'(k), keypos_ff[2:0]) != b) begin
                  cand_nx[k] = 1'b0;
               end
            end else if (keypos_ff == name_len(KEY_W'(k)) && b == 8'h00) begin
               lock_nx[k] = 1'b1;
            end else begin
               cand_nx[k] = 1'b0;
            end
         end
      end
      for (int k = ACTIVE_KEYS - 1; k >= 0; k--) begin
         if (cand_ff[k]) begin
            pick = KEY_W'(k);
         end
      end
   end

   always_comb begin
      logic       take;
      logic       raise;
      logic       start_str;
      logic [7:0] togo_dec;

      take      = req_ch.valid && !q_full;
      raise     = 1'b0;
      start_str = 1'b0;
      togo_dec  = togo_ff - 8'd1;

      phase_in    = phase_ff;
      togo_in     = togo_ff;
      keypos_in   = keypos_ff;
      cand_in     = cand_ff;
      lock_in     = lock_ff;
      mvalid_in   = mvalid_ff;
      mkey_in     = mkey_ff;
      err_seen_in = err_seen_ff;
      q_cmd       = '0;

      if (take) begin
         if (err_seen_ff) begin
            if (fin) begin
               err_seen_in = 1'b0;
               phase_in    = PH_LEN;
               togo_in     = 8'd0;
               start_str   = 1'b1;
            end
         end else begin
            case (phase_ff)
               PH_KEY: begin
                  togo_in = togo_dec;
                  if (b == ASSIGN_CHAR) begin
                     if (keypos_ff == '0 || togo_dec == 8'd0 || fin) begin
                        raise = 1'b1;
                     end else begin
                        mvalid_in = |cand_ff;
                        mkey_in   = pick;
                        phase_in  = PH_VAL;
                     end
                  end else begin
                     cand_in   = cand_nx;
                     lock_in   = lock_nx;
                     keypos_in = (keypos_ff == '1) ? keypos_ff : keypos_ff + 1'b1;
                     if (togo_dec == 8'd0 || fin) begin
                        raise = 1'b1;
                     end
                  end
               end
               PH_VAL: begin
                  togo_in        = togo_dec;
                  q_cmd.do_value = mvalid_ff;
                  q_cmd.key      = mkey_ff;
                  q_cmd.data     = b;
                  if (togo_dec == 8'd0) begin
                     q_cmd.do_commit = mvalid_ff;
                     phase_in        = PH_LEN;
                     start_str       = 1'b1;
                     q_cmd.do_end    = fin;
                  end else if (fin) begin
                     raise = 1'b1;
                  end
               end
               default: begin
                  if (b < MIN_LEN || fin) begin
                     raise = 1'b1;
                  end else begin
                     togo_in   = b;
                     start_str = 1'b1;
                     phase_in  = PH_KEY;
                  end
               end
            endcase
         end

         if (raise) begin
            q_cmd.do_end = 1'b1;
            q_cmd.end_err = 1'b1;
            phase_in     = PH_LEN;
            togo_in      = 8'd0;
            start_str    = 1'b1;
            err_seen_in  = !fin;
         end

         if (start_str) begin
            keypos_in = '0;
            cand_in   = '1;
            lock_in   = '0;
            mvalid_in = 1'b0;
            mkey_in   = '0;
         end
      end

      q_push = take && (q_cmd.do_value || q_cmd.do_commit || q_cmd.do_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_LEN;
         togo_ff     <= 8'd0;
         keypos_ff   <= '0;
         cand_ff     <= '1;
         lock_ff     <= '0;
         mvalid_ff   <= 1'b0;
         mkey_ff     <= '0;
         err_seen_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         togo_ff     <= togo_in;
         keypos_ff   <= keypos_in;
         cand_ff     <= cand_in;
         lock_ff     <= lock_in;
         mvalid_ff   <= mvalid_in;
         mkey_ff     <= mkey_in;
         err_seen_ff <= err_seen_in;
      end
   end

endmodule

// ===== design/txtkv_fifo.sv =====
`timescale 1ns / 1ps
module txtkv_fifo import txtkv_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    empty
);

   cmd_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/txtkv_back.sv =====
`timescale 1ns / 1ps
module txtkv_back import txtkv_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  cmd_type q_head,
   output logic    q_pop,
   txtkv_rsp_if.source rsp_ch
);

   logic             done_val_ff, done_val_in;
   logic             done_com_ff, done_com_in;
   logic             out_valid_ff, out_valid_in;
   logic [1:0]       kind_ff, kind_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [7:0]       byte_ff, byte_in;
   logic             err_ff, err_in;
   logic             last_ff, last_in;

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.kind        = kind_ff;
   assign rsp_ch.key_index   = key_ff;
   assign rsp_ch.value_byte  = byte_ff;
   assign rsp_ch.parse_error = err_ff;
   assign rsp_ch.run_last    = last_ff;

   // Results of one queue entry go out in order: value byte, commit, end.
   always_comb begin
      logic pend_val;
      logic pend_com;
      logic pend_end;
      logic load;

      pend_val = q_head.do_value && !done_val_ff;
      pend_com = q_head.do_commit && !done_com_ff;
      pend_end = q_head.do_end;
      load     = !q_empty && (!out_valid_ff || rsp_ch.ready);

      kind_in = kind_ff;
      key_in  = key_ff;
      byte_in = byte_ff;
      err_in  = err_ff;
      last_in = last_ff;
      done_val_in = done_val_ff;
      done_com_in = done_com_ff;
      q_pop = 1'b0;

      if (load) begin
         if (pend_val) begin
            kind_in = KIND_VALUE;
            key_in  = q_head.key;
            byte_in = q_head.data;
            err_in  = 1'b0;
            last_in = !(pend_com || pend_end);
            done_val_in = 1'b1;
         end else if (pend_com) begin
            kind_in = KIND_COMMIT;
            key_in  = q_head.key;
            byte_in = 8'd0;
            err_in  = 1'b0;
            last_in = !pend_end;
            done_com_in = 1'b1;
         end else begin
            kind_in = KIND_END;
            key_in  = '0;
            byte_in = 8'd0;
            err_in  = q_head.end_err;
            last_in = 1'b1;
         end
         if (last_in) begin
            q_pop       = 1'b1;
            done_val_in = 1'b0;
            done_com_in = 1'b0;
         end
      end

      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_val_ff  <= 1'b0;
         done_com_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         done_val_ff  <= done_val_in;
         done_com_ff  <= done_com_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      key_ff  <= key_in;
      byte_ff <= byte_in;
      err_ff  <= err_in;
      last_ff <= last_in;
   end

endmodule

// ===== design/txt_record_key_value_parser_unit.sv =====
// Path: a result enters the queue as its byte transfers, then the output register.
// Throughput: one byte per cycle while the queue is not full; results leave at one
// per cycle while ready is high; bytes causing two or three results are absorbed by
// the 4-entry queue and then slow input. Reset: synchronous, active high; the
// parser waits for a length byte, and the queue and output register are emptied.
`timescale 1ns / 1ps
module txt_record_key_value_parser_unit import txtkv_pkg::*; (
   input logic         clock,
   input logic         reset,
   txtkv_req_if.sink   req_ch,
   txtkv_rsp_if.source rsp_ch
);

   logic    q_full, q_push, q_empty, q_pop;
   cmd_type q_cmd, q_head;

   txtkv_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_cmd  (q_cmd)
   );

   txtkv_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   txtkv_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

// ===== design/txtkv_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module txtkv_checker import txtkv_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_value_byte,
   input logic       rsp_parse_error,
   input logic       rsp_run_last
);

   `TXTKV_ASSERT_NOW(a_end_is_last, clock, reset, rsp_valid && rsp_kind == KIND_END, rsp_run_last, "End of parse must be the last result of its byte.")
   `TXTKV_ASSERT_NOW(a_err_only_end, clock, reset, rsp_valid && rsp_kind != KIND_END, !rsp_parse_error, "Parse error flag set on a result that is not end of parse.")
   `TXTKV_ASSERT_NOW(a_byte_only_value, clock, reset, rsp_valid && rsp_kind != KIND_VALUE, rsp_value_byte == 8'd0, "Value byte nonzero on a result that is not a value byte.")
   `TXTKV_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_value_byte), "Stalled result changed before its transfer.")

endmodule

bind txt_record_key_value_parser_unit txtkv_checker u_txtkv_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_kind        (rsp_ch.kind),
   .rsp_value_byte  (rsp_ch.value_byte),
   .rsp_parse_error (rsp_ch.parse_error),
   .rsp_run_last    (rsp_ch.run_last)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import txtkv_pkg::*;

   localparam int IDLE_LIMIT = 1000;
   localparam int RANDOM_BYTES = 250;

   typedef logic [7:0] byte_q_type[$];

   typedef struct {
      logic [1:0] kind;
      logic [2:0] key_index;
      logic [7:0] value_byte;
      logic       parse_error;
      logic       run_last;
   } txt_result_type;

   class kv_parse_predictor;
      phase_type   phase;
      logic [7:0]  remaining;
      logic [7:0]  key_pos;
      logic [7:0]  cand_mask;
      logic [7:0]  lock_mask;
      logic [2:0]  hit_key;
      bit          hit_valid;
      bit          draining;
      int          failures;
      txt_result_type batch[$];
      txt_result_type expected_results[$];

      function new();
         failures = 0;
         restart();
      endfunction

      static function string key_name(int k);
         case (k)
            0: return "txtvers";
            1: return "id";
            2: return "path";
            3: return "ski";
            4: return "register";
            5: return "brand";
            6: return "type";
            default: return "model";
         endcase
      endfunction

      function void restart_string();
         key_pos = 0;
         cand_mask = 8'hFF;
         lock_mask = 0;
         hit_key = 0;
         hit_valid = 0;
      endfunction

      function void restart();
         phase = PH_LEN;
         remaining = 0;
         draining = 0;
         restart_string();
      endfunction

      function void push(logic [1:0] kind, logic [2:0] key, logic [7:0] value, logic err);
         txt_result_type r;
         r.kind = kind;
         r.key_index = key;
         r.value_byte = value;
         r.parse_error = err;
         r.run_last = 0;
         batch.push_back(r);
      endfunction

      function void flag_error(bit fin);
         push(KIND_END, 3'd0, 8'd0, 1'b1);
         phase = PH_LEN;
         remaining = 0;
         restart_string();
         draining = !fin;
      endfunction

      function void match_key_byte(logic [7:0] b);
         string s;
         int n;
         for (int k = 0; k < ACTIVE_KEYS; k++) begin
            if (!cand_mask[k] || lock_mask[k]) continue;
            s = key_name(k);
            n = s.len();
            if (key_pos < n) begin
               if (s[key_pos] != b) cand_mask[k] = 1'b0;
            end else if (key_pos == n && b == 8'd0) begin
               lock_mask[k] = 1'b1;
            end else begin
               cand_mask[k] = 1'b0;
            end
         end
      endfunction

      function void pick_key();
         hit_valid = 0;
         hit_key = 0;
         for (int k = 0; k < ACTIVE_KEYS; k++) begin
            if (cand_mask[k]) begin
               hit_key = k[2:0];
               hit_valid = 1;
               break;
            end
         end
      endfunction

      function void note_byte(logic [7:0] b, bit fin);
         batch.delete();
         if (draining) begin
            if (fin) restart();
            return;
         end
         case (phase)
            PH_KEY: begin
               remaining--;
               if (b == ASSIGN_CHAR) begin
                  if (key_pos == 0 || remaining == 0 || fin) begin
                     flag_error(fin);
                  end else begin
                     pick_key();
                     phase = PH_VAL;
                  end
               end else begin
                  match_key_byte(b);
                  if (key_pos != 8'hFF) key_pos++;
                  if (remaining == 0 || fin) flag_error(fin);
               end
            end
            PH_VAL: begin
               remaining--;
               if (hit_valid) push(KIND_VALUE, hit_key, b, 1'b0);
               if (remaining == 0) begin
                  if (hit_valid) push(KIND_COMMIT, hit_key, 8'd0, 1'b0);
                  phase = PH_LEN;
                  restart_string();
                  if (fin) begin
                     push(KIND_END, 3'd0, 8'd0, 1'b0);
                     restart();
                  end
               end else if (fin) begin
                  flag_error(fin);
               end
            end
            default: begin
               if (b < MIN_LEN || fin) begin
                  flag_error(fin);
               end else begin
                  remaining = b;
                  restart_string();
                  phase = PH_KEY;
               end
            end
         endcase
         if (batch.size() > 0) batch[batch.size() - 1].run_last = 1'b1;
         foreach (batch[i]) expected_results.push_back(batch[i]);
      endfunction

      function void check_result(txt_result_type got);
         txt_result_type exp;
         if (expected_results.size() == 0) begin
            $error("unexpected result: kind %0d key_index %0d value_byte %0d",
                   got.kind, got.key_index, got.value_byte);
            failures++;
            return;
         end
         exp = expected_results.pop_front();
         if (got.kind !== exp.kind) begin
            $error("kind: expected %0d, actual %0d", exp.kind, got.kind);
            failures++;
         end
         if (got.key_index !== exp.key_index) begin
            $error("key_index: expected %0d, actual %0d", exp.key_index, got.key_index);
            failures++;
         end
         if (got.value_byte !== exp.value_byte) begin
            $error("value_byte: expected %0d, actual %0d", exp.value_byte, got.value_byte);
            failures++;
         end
         if (got.parse_error !== exp.parse_error) begin
            $error("parse_error: expected %0d, actual %0d", exp.parse_error,
                   got.parse_error);
            failures++;
         end
         if (got.run_last !== exp.run_last) begin
            $error("run_last: expected %0d, actual %0d", exp.run_last, got.run_last);
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   txtkv_req_if req_ch();
   txtkv_rsp_if rsp_ch();

   kv_parse_predictor parser_model = new();
   int  bytes_sent = 0;
   int  idle_cycles = 0;
   bit  calm_send = 0;
   bit  calm_recv = 0;

   txt_record_key_value_parser_unit dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      if (c == ASSIGN_CHAR) c = 8'h3E;
      return c;
   endfunction

   function automatic byte_q_type entry(string text);
      byte_q_type q;
      q.push_back(8'(text.len()));
      for (int i = 0; i < text.len(); i++) q.push_back(text[i]);
      return q;
   endfunction

   function automatic byte_q_type random_entry();
      byte_q_type key;
      byte_q_type q;
      string   name;
      int      mode;
      int      vlen;
      int      cut;
      mode = $urandom_range(0, 9);
      name = kv_parse_predictor::key_name($urandom_range(0, 7));
      if (mode <= 7) begin
         cut = (mode <= 5) ? name.len() : $urandom_range(1, name.len());
         for (int i = 0; i < cut; i++) key.push_back(name[i]);
      end else if (mode == 8) begin
         repeat ($urandom_range(1, 6)) key.push_back(plain_char());
      end else begin
         for (int i = 0; i < name.len(); i++) key.push_back(name[i]);
         key.push_back(8'h00);
         repeat ($urandom_range(0, 3)) key.push_back(plain_char());
      end
      if ($urandom_range(0, 29) == 0) vlen = $urandom_range(1, 254 - key.size());
      else vlen = $urandom_range(1, 6);
      q.push_back(8'(key.size() + 1 + vlen));
      q = {q, key};
      q.push_back(ASSIGN_CHAR);
      repeat (vlen) q.push_back(8'($urandom_range(0, 255)));
      return q;
   endfunction

   function automatic byte_q_type random_record();
      byte_q_type rec;
      int      len;
      repeat ($urandom_range(1, 4)) rec = {rec, random_entry()};
      if ($urandom_range(0, 4) == 0) begin
         len = $urandom_range(3, 8);
         case ($urandom_range(0, 5))
            0: begin
               rec.push_back(8'($urandom_range(0, 2)));
               repeat ($urandom_range(1, 3)) rec.push_back(8'($urandom_range(0, 255)));
            end
            1: begin
               rec.push_back(8'(len));
               repeat (len) rec.push_back(plain_char());
            end
            2: begin
               rec.push_back(8'(len));
               rec.push_back(ASSIGN_CHAR);
               repeat (len - 1) rec.push_back(8'($urandom_range(0, 255)));
            end
            3: begin
               rec.push_back(8'(len));
               repeat (len - 1) rec.push_back(plain_char());
               rec.push_back(ASSIGN_CHAR);
            end
            4: rec = rec[0:$urandom_range(0, rec.size() - 2)];
            default: begin
               rec.delete();
               repeat ($urandom_range(1, 20)) rec.push_back(8'($urandom_range(0, 255)));
            end
         endcase
      end
      return rec;
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit fin);
      int gap;
      gap = calm_send ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.final_byte <= fin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      parser_model.note_byte(b, fin);
      bytes_sent++;
   endtask

   task automatic send_record(input byte_q_type rec);
      foreach (rec[i]) send_byte(rec[i], i == rec.size() - 1);
   endtask

   task automatic run_directed();
      send_record({entry("txtvers=1"), entry("id=ab"), entry("path=/")});
      send_record({entry("ski=x"), entry("register=y"), entry("brand=z")});
      send_record({entry("type=t"), entry("model=m"), entry("t=q"), entry("i==")});
      send_record({entry("zz=q"), entry("typ=v")});
      send_record({8'd4, 8'h69, 8'h64, 8'h3D, 8'h00, 8'd4, 8'h69, 8'h64, 8'h3D, 8'hFF});
      send_record({8'd5, 8'h69, 8'h64, 8'h00, 8'h3D, 8'h76,
                   8'd6, 8'h69, 8'h64, 8'h00, 8'h78, 8'h3D, 8'h76,
                   8'd5, 8'h69, 8'h64, 8'h01, 8'h3D, 8'h76});
      send_record({8'd2, 8'h61, 8'h62});
      send_record({8'd0, 8'h41});
      send_record({8'd3, 8'h3D, 8'h61, 8'h62});
      send_record({8'd3, 8'h69, 8'h64, 8'h3D});
      send_record({8'd3, 8'h61, 8'h62, 8'h63});
      send_record({8'd5, 8'h69, 8'h64, 8'h3D, 8'h78});
      send_record({entry("id=1"), 8'd7});
      send_record({8'd6, 8'h69, 8'h64});
      send_record({8'd6, 8'h69, 8'h64, 8'h3D});
   endtask

   initial begin
      txt_result_type got;
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) calm_recv = !calm_recv;
         stall = calm_recv ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         got.kind = rsp_ch.kind;
         got.key_index = rsp_ch.key_index;
         got.value_byte = rsp_ch.value_byte;
         got.parse_error = rsp_ch.parse_error;
         got.run_last = rsp_ch.run_last;
         parser_model.check_result(got);
      end
   end

   initial begin
      int target;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data_byte <= 8'd0;
      req_ch.final_byte <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      target = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < target) begin
         calm_send = ($urandom_range(0, 3) == 0);
         send_record(random_record());
      end
      req_ch.valid <= 1'b0;
      while (parser_model.expected_results.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (parser_model.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
